// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the pid controller top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition checked at every rising clock edge outside reset
`define PIDAW_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define PIDAW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pidaw_pkg.sv =====
// types, constants and fixed-point helpers for the pid controller
package pidaw_pkg;

  localparam int QW     = 32;
  localparam int PoleW  = 18;
  localparam int Frac   = 16;
  localparam int WideW  = 48;
  localparam int ProdW  = 2 * QW;
  localparam int AddrW  = 5;
  localparam int DataW  = 32;
  localparam int IdxW   = 3;

  localparam logic signed [QW-1:0] QMax = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] QMin = {1'b1, {(QW-1){1'b0}}};
  localparam logic signed [WideW-1:0] WideMax = WideW'(QMax);
  localparam logic signed [WideW-1:0] WideMin = WideW'(QMin);
  localparam logic signed [ProdW-1:0] RoundHalf = ProdW'(1) <<< (Frac - 1);

  localparam logic signed [QW-1:0]    PropGainRst  = QW'(65536);
  localparam logic signed [QW-1:0]    IntGainRst   = '0;
  localparam logic signed [QW-1:0]    DerivGainRst = '0;
  localparam logic signed [PoleW-1:0] DerivPoleRst = '0;
  localparam logic signed [QW-1:0]    OutMinRst    = QMin;
  localparam logic signed [QW-1:0]    OutMaxRst    = QMax;

  typedef enum logic [IdxW-1:0] {
    RegPropGain  = 3'd0,
    RegIntGain   = 3'd1,
    RegDerivGain = 3'd2,
    RegDerivPole = 3'd3,
    RegOutMin    = 3'd4,
    RegOutMax    = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [QW-1:0]    prop_gain;
    logic signed [QW-1:0]    int_gain;
    logic signed [QW-1:0]    deriv_gain;
    logic signed [PoleW-1:0] deriv_pole;
    logic signed [QW-1:0]    out_min;
    logic signed [QW-1:0]    out_max;
  } cfg_t;

  function automatic logic signed [QW-1:0] sat_q(input logic signed [WideW-1:0] v);
    logic signed [QW-1:0] r;
    if (v > WideMax) begin
      r = QMax;
    end else if (v < WideMin) begin
      r = QMin;
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [QW-1:0] add_q(input logic signed [QW-1:0] a,
                                                 input logic signed [QW-1:0] b);
    return sat_q(WideW'(a) + WideW'(b));
  endfunction

  function automatic logic signed [QW-1:0] sub_q(input logic signed [QW-1:0] a,
                                                 input logic signed [QW-1:0] b);
    return sat_q(WideW'(a) - WideW'(b));
  endfunction

  function automatic logic signed [QW-1:0] add3_q(input logic signed [QW-1:0] a,
                                                  input logic signed [QW-1:0] b,
                                                  input logic signed [QW-1:0] c);
    return sat_q(WideW'(a) + WideW'(b) + WideW'(c));
  endfunction

  function automatic logic signed [QW-1:0] neg_q(input logic signed [QW-1:0] a);
    return sat_q(-WideW'(a));
  endfunction

  // q16.16 product, round half up, saturate
  function automatic logic signed [QW-1:0] mul_q(input logic signed [QW-1:0] a,
                                                 input logic signed [QW-1:0] b);
    logic signed [ProdW-1:0] p;
    logic signed [ProdW-1:0] s;
    p = ProdW'(a) * ProdW'(b);
    s = (p + RoundHalf) >>> Frac;
    return sat_q(s[WideW-1:0]);
  endfunction

endpackage

// ===== rtl/core/pidaw_regs.sv =====
// apb register file holding gains, pole and output limits
module pidaw_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pidaw_pkg::AddrW-1:0]   paddr,
  input  logic [pidaw_pkg::DataW-1:0]   pwdata,
  output logic [pidaw_pkg::DataW-1:0]   prdata,
  output logic                          pready,
  output pidaw_pkg::cfg_t               cfg_o
);

  pidaw_pkg::cfg_t     cfg_q;
  logic                wr_en;
  pidaw_pkg::reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = pidaw_pkg::reg_idx_e'(paddr[pidaw_pkg::AddrW-1:2]);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain  <= pidaw_pkg::PropGainRst;
      cfg_q.int_gain   <= pidaw_pkg::IntGainRst;
      cfg_q.deriv_gain <= pidaw_pkg::DerivGainRst;
      cfg_q.deriv_pole <= pidaw_pkg::DerivPoleRst;
      cfg_q.out_min    <= pidaw_pkg::OutMinRst;
      cfg_q.out_max    <= pidaw_pkg::OutMaxRst;
    end else if (wr_en) begin
      case (idx)
        pidaw_pkg::RegPropGain:  cfg_q.prop_gain  <= pwdata;
        pidaw_pkg::RegIntGain:   cfg_q.int_gain   <= pwdata;
        pidaw_pkg::RegDerivGain: cfg_q.deriv_gain <= pwdata;
        pidaw_pkg::RegDerivPole: cfg_q.deriv_pole <= pwdata[pidaw_pkg::PoleW-1:0];
        pidaw_pkg::RegOutMin:    cfg_q.out_min    <= pwdata;
        pidaw_pkg::RegOutMax:    cfg_q.out_max    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pidaw_pkg::RegPropGain:  prdata = cfg_q.prop_gain;
      pidaw_pkg::RegIntGain:   prdata = cfg_q.int_gain;
      pidaw_pkg::RegDerivGain: prdata = cfg_q.deriv_gain;
      pidaw_pkg::RegDerivPole: prdata = pidaw_pkg::DataW'(cfg_q.deriv_pole);
      pidaw_pkg::RegOutMin:    prdata = cfg_q.out_min;
      pidaw_pkg::RegOutMax:    prdata = cfg_q.out_max;
      default:                 prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/pid_controller_antiwindup.sv =====
// pid controller top level: input register, single-pass datapath, result register
//
//   channel   dir   handshake              payload
//   s_axis    in    tvalid/tready          tdata {sample, target}, tuser restart
//   m_axis    out   tvalid/tready          tdata {deriv, integral, drive},
//                                          tuser {wound_up, clamped}
//   apb       in    psel/penable/pready    six config registers at 4*i
//
// one request per cycle while the output is not stalled; results pass the input then result register
// the integrator and derivative recurrence closes in the single combinational datapath pass
// reset clears state, the freeze flag and both valid bits; config returns to reset values
// a stalled result keeps the input register full, then s_axis_tready drops
`include "assert_macros.svh"

module pid_controller_antiwindup (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [2*pidaw_pkg::QW-1:0]          s_axis_tdata,   // target, sample
  input  logic                                s_axis_tuser,   // restart
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [3*pidaw_pkg::QW-1:0]          m_axis_tdata,   // drive, integral_now, derivative_now
  output logic [1:0]                          m_axis_tuser,   // clamped, wound_up
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pidaw_pkg::AddrW-1:0]         paddr,
  input  logic [pidaw_pkg::DataW-1:0]         pwdata,
  output logic [pidaw_pkg::DataW-1:0]         prdata,
  output logic                                pready
);

  localparam int QW = pidaw_pkg::QW;

  pidaw_pkg::cfg_t cfg;

  pidaw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register
  logic                 in_valid_q, in_valid_d;
  logic signed [QW-1:0] tgt_q, smp_q;
  logic                 restart_q;
  logic                 advance, fire;

  // state
  logic signed [QW-1:0] integ_q, integ_d;
  logic signed [QW-1:0] last_err_q;
  logic signed [QW-1:0] deriv_q, deriv_d;
  logic signed [QW-1:0] last_smp_q;
  logic                 freeze_q;

  // result register
  logic                 out_valid_q, out_valid_d;
  logic signed [QW-1:0] drive_q, drive_d;
  logic signed [QW-1:0] integ_out_q, deriv_out_q;
  logic                 clamped_q, clamped_d;
  logic                 wound_q, wound_d;

  // datapath
  logic signed [QW-1:0] integ_s, last_err_s, deriv_s, last_smp_s;
  logic                 freeze_s;
  logic signed [QW-1:0] err, prop, esum, dmeas, dsum, total;

  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_valid_d    = s_axis_tready ? s_axis_tvalid : in_valid_q;
  assign out_valid_d   = advance ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      tgt_q     <= s_axis_tdata[QW-1:0];
      smp_q     <= s_axis_tdata[2*QW-1:QW];
      restart_q <= s_axis_tuser;
    end
  end

  always_comb begin
    integ_s    = restart_q ? '0 : integ_q;
    last_err_s = restart_q ? '0 : last_err_q;
    deriv_s    = restart_q ? '0 : deriv_q;
    last_smp_s = restart_q ? '0 : last_smp_q;
    freeze_s   = restart_q ? 1'b0 : freeze_q;

    err   = pidaw_pkg::sub_q(tgt_q, smp_q);
    prop  = pidaw_pkg::mul_q(cfg.prop_gain, err);
    esum  = pidaw_pkg::add_q(err, last_err_s);
    integ_d = freeze_s ? integ_s
                       : pidaw_pkg::add_q(integ_s, pidaw_pkg::mul_q(cfg.int_gain, esum));
    dmeas = pidaw_pkg::sub_q(smp_q, last_smp_s);
    dsum  = pidaw_pkg::add_q(pidaw_pkg::mul_q(cfg.deriv_gain, dmeas),
                             pidaw_pkg::mul_q(QW'(cfg.deriv_pole), deriv_s));
    deriv_d = pidaw_pkg::neg_q(dsum);
    total = pidaw_pkg::add3_q(prop, integ_d, deriv_d);

    // with inverted limits the upper limit wins when total is above it, else the lower limit
    if (total > cfg.out_max) begin
      drive_d = cfg.out_max;
    end else if (total < cfg.out_min) begin
      drive_d = cfg.out_min;
    end else begin
      drive_d = total;
    end
    clamped_d = (drive_d != total);
    wound_d   = clamped_d && (((err < 0) && (total < 0)) || ((err > 0) && (total > 0)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      integ_q     <= '0;
      last_err_q  <= '0;
      deriv_q     <= '0;
      last_smp_q  <= '0;
      freeze_q    <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        integ_q    <= integ_d;
        last_err_q <= err;
        deriv_q    <= deriv_d;
        last_smp_q <= smp_q;
        freeze_q   <= wound_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      drive_q     <= drive_d;
      integ_out_q <= integ_d;
      deriv_out_q <= deriv_d;
      clamped_q   <= clamped_d;
      wound_q     <= wound_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {deriv_out_q, integ_out_q, drive_q};
  assign m_axis_tuser  = {wound_q, clamped_q};

  `PIDAW_ASSERT(a_wound_needs_clamp, !(out_valid_q && wound_q && !clamped_q),
                "wound_up without clamped")
  `PIDAW_ASSERT(a_drive_in_limits,
                !(out_valid_q && (cfg.out_min <= cfg.out_max)) ||
                ((drive_q >= cfg.out_min) && (drive_q <= cfg.out_max)),
                "drive outside limits")
  `PIDAW_ASSERT_NEXT(a_freeze_tracks_result, fire, freeze_q == wound_q,
                     "freeze flag differs from delivered wound_up")
  `PIDAW_ASSERT_NEXT(a_item_moves_to_output, in_valid_q && !out_valid_q, out_valid_q,
                     "pending request did not reach the result register")

endmodule

// ===== tb/pid_controller_antiwindup_test.sv =====
`timescale 1ns / 1ps
// testbench for the anti-windup pid controller: streamed requests, apb config, predicted outputs
module pid_controller_antiwindup_test;

  localparam int LatencyCycles = 2;
  localparam int IdleLimit = 1000;
  localparam int QOne = 65536;
  localparam int RandomPhases = 8;
  localparam int ItemsPerPhase = 104;
  localparam int QW = pidaw_pkg::QW;
  localparam int PoleW = pidaw_pkg::PoleW;
  localparam logic [pidaw_pkg::IdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [pidaw_pkg::IdxW-1:0] RegSpareHi = 3'd7;

  typedef struct packed {
    logic [QW-1:0] target;
    logic [QW-1:0] sample;
    logic          restart;
  } setpoint_req_t;

  typedef struct packed {
    logic [QW-1:0] drive;
    logic [QW-1:0] integral;
    logic [QW-1:0] derivative;
    logic          clamped;
    logic          wound_up;
  } ctl_out_t;

  typedef enum logic [1:0] {RxFull, RxRandom, RxSparse} rx_mode_e;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [2*QW-1:0]               s_axis_tdata = '0;
  logic                          s_axis_tuser = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [3*QW-1:0]               m_axis_tdata;
  logic [1:0]                    m_axis_tuser;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [pidaw_pkg::AddrW-1:0]   paddr = '0;
  logic [pidaw_pkg::DataW-1:0]   pwdata = '0;
  logic [pidaw_pkg::DataW-1:0]   prdata;
  logic                          pready;

  // controller settings as last written
  logic signed [QW-1:0]    gain_p, gain_i, gain_d, lim_lo, lim_hi;
  logic signed [PoleW-1:0] pole;
  // controller state
  logic signed [QW-1:0]    integ_acc, prev_err, deriv_acc, prev_sample;
  logic                    frozen;

  setpoint_req_t pending_setpoints[$];
  ctl_out_t      predicted_outputs[$];
  setpoint_req_t drv_req;
  ctl_out_t      want;
  int            setpoints_queued = 0;
  int            outputs_seen = 0;
  int            errors = 0;
  int            burst_left = 0;
  int            gap_left = 0;
  int            stall_cycles = 0;
  logic          in_fire = 1'b0;
  logic [31:0]   rx_tick = '0;
  rx_mode_e      rx_mode = RxFull;

  pid_controller_antiwindup uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic signed [QW-1:0] clip32(input longint v);
    if (v > 64'sd2147483647) return pidaw_pkg::QMax;
    if (v < -64'sd2147483648) return pidaw_pkg::QMin;
    return 32'(v);
  endfunction

  function automatic logic signed [QW-1:0] qmul(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return clip32((p + 64'sd32768) >>> pidaw_pkg::Frac);
  endfunction

  function automatic ctl_out_t pid_advance(input logic signed [QW-1:0] tgt,
                                           input logic signed [QW-1:0] meas,
                                           input logic restart);
    logic signed [QW-1:0] err, prop, esum, dsum, total, drv, pole32;
    ctl_out_t res;
    if (restart) begin
      integ_acc = '0;
      prev_err = '0;
      deriv_acc = '0;
      prev_sample = '0;
      frozen = 1'b0;
    end
    pole32 = {{(QW-PoleW){pole[PoleW-1]}}, pole};
    err = clip32(longint'(tgt) - longint'(meas));
    prop = qmul(gain_p, err);
    if (!frozen) begin
      esum = clip32(longint'(err) + longint'(prev_err));
      integ_acc = clip32(longint'(integ_acc) + longint'(qmul(gain_i, esum)));
    end
    dsum = clip32(longint'(qmul(gain_d, clip32(longint'(meas) - longint'(prev_sample))))
                  + longint'(qmul(pole32, deriv_acc)));
    deriv_acc = clip32(-longint'(dsum));
    total = clip32(longint'(prop) + longint'(integ_acc) + longint'(deriv_acc));
    drv = total;
    if (drv > lim_hi) begin
      drv = lim_hi;
    end else if (drv < lim_lo) begin
      drv = lim_lo;
    end
    res.drive = drv;
    res.integral = integ_acc;
    res.derivative = deriv_acc;
    res.clamped = (drv != total);
    res.wound_up = res.clamped && ((err < 0 && total < 0) || (err > 0 && total > 0));
    frozen = res.wound_up;
    prev_err = err;
    prev_sample = meas;
    return res;
  endfunction

  function automatic logic [31:0] pick_q(input int unsigned spread);
    int unsigned sel;
    logic [31:0] v;
    sel = $urandom_range(0, 15);
    if (sel == 0) begin
      v = pidaw_pkg::QMax;
    end else if (sel == 1) begin
      v = pidaw_pkg::QMin;
    end else if (sel == 2) begin
      v = '0;
    end else if (sel < 6) begin
      v = $urandom;
    end else begin
      v = $urandom_range(0, 2 * spread) - spread;
    end
    return v;
  endfunction

  task automatic report_diff(input string what, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
      errors++;
    end
  endtask

  // sender: bursts of requests with random gaps
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || in_fire) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_setpoints.size() != 0) begin
        drv_req = pending_setpoints.pop_front();
        s_axis_tdata <= {drv_req.sample, drv_req.target};
        s_axis_tuser <= drv_req.restart;
        s_axis_tvalid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left = burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern picked at random from full, random and sparse ready
  always @(negedge clk_i) begin
    rx_tick = rx_tick + 1;
    if (rx_tick[6:0] == '0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
    end
    case (rx_mode)
      RxFull: begin
        m_axis_tready <= 1'b1;
      end
      RxRandom: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      default: begin
        m_axis_tready <= (rx_tick[1:0] == 2'b11);
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        outputs_seen <= outputs_seen + 1;
        if (predicted_outputs.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h %b", $time,
                   m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          want = predicted_outputs.pop_front();
          report_diff("drive", want.drive, m_axis_tdata[QW-1:0]);
          report_diff("integral", want.integral, m_axis_tdata[2*QW-1:QW]);
          report_diff("derivative", want.derivative, m_axis_tdata[3*QW-1:2*QW]);
          report_diff("clamped", 32'(want.clamped), 32'(m_axis_tuser[0]));
          report_diff("wound_up", 32'(want.wound_up), 32'(m_axis_tuser[1]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_outputs.push_back(pid_advance(s_axis_tdata[QW-1:0],
                                                s_axis_tdata[2*QW-1:QW], s_axis_tuser));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          outputs_seen == setpoints_queued) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= IdleLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic queue_setpoint(input logic [31:0] tgt, input logic [31:0] meas,
                                input logic restart);
    setpoint_req_t r;
    r.target = tgt;
    r.sample = meas;
    r.restart = restart;
    pending_setpoints.push_back(r);
    setpoints_queued++;
  endtask

  task automatic cfg_write(input logic [pidaw_pkg::IdxW-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      pidaw_pkg::RegPropGain:  gain_p = val;
      pidaw_pkg::RegIntGain:   gain_i = val;
      pidaw_pkg::RegDerivGain: gain_d = val;
      pidaw_pkg::RegDerivPole: pole = val[PoleW-1:0];
      pidaw_pkg::RegOutMin:    lim_lo = val;
      pidaw_pkg::RegOutMax:    lim_hi = val;
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic cfg_all(input logic [31:0] kp, input logic [31:0] ki, input logic [31:0] kd,
                         input logic [31:0] pl, input logic [31:0] lo, input logic [31:0] hi);
    cfg_write(pidaw_pkg::RegPropGain, kp);
    cfg_write(pidaw_pkg::RegIntGain, ki);
    cfg_write(pidaw_pkg::RegDerivGain, kd);
    cfg_write(pidaw_pkg::RegDerivPole, pl);
    cfg_write(pidaw_pkg::RegOutMin, lo);
    cfg_write(pidaw_pkg::RegOutMax, hi);
  endtask

  task automatic wait_drained();
    while (outputs_seen != setpoints_queued) @(negedge clk_i);
    repeat (LatencyCycles + 2) @(negedge clk_i);
  endtask

  initial begin
    logic [31:0] a, b, lo, hi, pl, set_lvl, meas_lvl;
    int unsigned sel;
    gain_p = pidaw_pkg::PropGainRst;
    gain_i = pidaw_pkg::IntGainRst;
    gain_d = pidaw_pkg::DerivGainRst;
    pole = pidaw_pkg::DerivPoleRst;
    lim_lo = pidaw_pkg::OutMinRst;
    lim_hi = pidaw_pkg::OutMaxRst;
    integ_acc = '0;
    prev_err = '0;
    deriv_acc = '0;
    prev_sample = '0;
    frozen = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, error saturation both ways
    queue_setpoint('0, '0, 1'b0);
    queue_setpoint(pidaw_pkg::QMax, pidaw_pkg::QMin, 1'b0);
    queue_setpoint(pidaw_pkg::QMin, pidaw_pkg::QMax, 1'b0);
    queue_setpoint(32'(QOne), 32'(-QOne), 1'b0);
    queue_setpoint(pidaw_pkg::QMax, pidaw_pkg::QMax, 1'b1);
    wait_drained();

    // narrow limits, drive into windup and restart out of it
    cfg_all(32'(2 * QOne), 32'(QOne / 4), 32'(QOne / 2), 32'(QOne),
            32'(-10 * QOne), 32'(10 * QOne));
    repeat (3) queue_setpoint(32'(20 * QOne), '0, 1'b0);
    queue_setpoint(32'(-20 * QOne), '0, 1'b0);
    queue_setpoint('0, 32'(5 * QOne), 1'b0);
    queue_setpoint('0, pidaw_pkg::QMin, 1'b0);
    queue_setpoint('0, pidaw_pkg::QMax, 1'b0);
    queue_setpoint(32'(3 * QOne), 32'(QOne), 1'b1);
    queue_setpoint(32'(20 * QOne), '0, 1'b0);
    wait_drained();

    // extreme gains, negative unit pole
    cfg_all(pidaw_pkg::QMax, pidaw_pkg::QMin, pidaw_pkg::QMax, 32'(-QOne),
            pidaw_pkg::QMin, pidaw_pkg::QMax);
    queue_setpoint(pidaw_pkg::QMax, pidaw_pkg::QMin, 1'b0);
    queue_setpoint(pidaw_pkg::QMin, pidaw_pkg::QMax, 1'b0);
    queue_setpoint(32'd1, '0, 1'b0);
    queue_setpoint(32'hFFFF_FFFF, '0, 1'b0);
    wait_drained();

    // inverted limits, pole at the most negative code, writes to unused slots
    cfg_all(32'(QOne), pidaw_pkg::QMax, 32'(QOne), 32'h0002_0000, 32'(5 * QOne),
            32'(-5 * QOne));
    cfg_write(RegSpareLo, 32'hFFFF_FFFF);
    cfg_write(RegSpareHi, 32'h5A5A_A5A5);
    queue_setpoint(32'(10 * QOne), '0, 1'b0);
    queue_setpoint(32'(-10 * QOne), '0, 1'b0);
    queue_setpoint('0, '0, 1'b0);
    queue_setpoint(32'(QOne), 32'(2 * QOne), 1'b0);
    wait_drained();

    for (int ph = 0; ph < RandomPhases; ph++) begin
      sel = $urandom_range(0, 7);
      if (sel < 2) begin
        pl = $urandom;
      end else if (sel == 2) begin
        pl = 32'(QOne);
      end else if (sel == 3) begin
        pl = 32'(-QOne);
      end else begin
        pl = $urandom_range(0, 2 * QOne) - QOne;
      end
      a = pick_q(1 << 22);
      b = pick_q(1 << 22);
      if ($urandom_range(0, 5) != 0 && $signed(a) > $signed(b)) begin
        lo = b;
        hi = a;
      end else begin
        lo = a;
        hi = b;
      end
      cfg_all(pick_q(4 * QOne), pick_q(QOne), pick_q(2 * QOne), pl, lo, hi);
      if (ph == RandomPhases - 1) begin
        cfg_write(RegSpareLo, $urandom);
      end
      set_lvl = pick_q(1 << 21);
      meas_lvl = '0;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          queue_setpoint(pick_q(1 << 24), pick_q(1 << 24), ($urandom_range(0, 24) == 0));
        end else begin
          if ($urandom_range(0, 19) == 0) begin
            set_lvl = pick_q(1 << 21);
          end
          meas_lvl = meas_lvl + ($urandom_range(0, 1 << 17) - (1 << 16));
          queue_setpoint(set_lvl, meas_lvl, ($urandom_range(0, 24) == 0));
        end
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== pid_controller_antiwindup.f =====
+incdir+rtl/core
rtl/core/pidaw_pkg.sv
rtl/core/pidaw_regs.sv
rtl/core/pid_controller_antiwindup.sv
tb/pid_controller_antiwindup_test.sv
